@@ hw/rtl/swm_pkg.sv @@
// Shared types, constants and the star-closure function for the star wildcard matcher.
// No dependencies; every other file of the block but swm_checker imports this package.
package swm_pkg;

	localparam int PAT_MAX   = 32;              // pattern bytes held
	localparam int PAT_WORDS = PAT_MAX / 8;     // 64-bit config words
	localparam int POS_W     = PAT_MAX + 1;     // positions 0..PAT_MAX
	localparam int LEN_W     = 6;               // pattern_length register width
	localparam int IDX_W     = 3;               // config index width
	localparam int DATA_W    = 64;              // widest config register
	localparam int WSEL_W    = $clog2(PAT_WORDS);

	localparam logic [7:0] STAR_BYTE = 8'h2A;

	// config register indexes
	localparam logic [IDX_W-1:0] REG_LEN   = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_WORD0 = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_WORDN = IDX_W'(PAT_WORDS);

	typedef logic [POS_W-1:0] pos_vec_t;

	// pattern view handed from the config block to the datapath
	typedef struct packed {
		logic [PAT_MAX-1:0][7:0] bytes;
		pos_vec_t                star;  // position p < len holds '*'
		pos_vec_t                live;  // position p <= len
		logic [LEN_W-1:0]        len;   // clamped length
	} pat_t;

	// Star closure as one carry chain: a carry entering a run of stars
	// ripples to the first non-star position after the run.
	function automatic pos_vec_t close_stars(input pos_vec_t a, input pos_vec_t star,
			input pos_vec_t live);
		pos_vec_t am;
		pos_vec_t x;
		am = a & live;
		x  = am & star;
		return (((x + star) ^ star) | am) & live;
	endfunction

endpackage

@@ hw/rtl/star_wildcard_matcher.sv @@
// Star wildcard matcher: a streamed text, one byte per beat, against a '*' pattern.
// Throughput one beat per cycle when not stalled; a last beat passes the input register
// and then loads its result into the result register. Only a last beat waits on a stalled result.
// A config write stalls the input in the cycle of the write only.
// Reset (arst_n low, async): all config registers 0, position set back to start.
// Depends on swm_pkg, swm_cfg and swm_step.
module star_wildcard_matcher (
	input  logic                        clk,
	input  logic                        arst_n,
	// config write port
	input  logic                        cfg_we,
	input  logic [swm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [swm_pkg::DATA_W-1:0]  cfg_data,
	// text beats
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  text_char,
	input  logic                        is_empty,
	input  logic                        last,
	// result beats
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        matched
);
	import swm_pkg::*;

	pat_t     pat;
	pos_vec_t state_q;      // active positions; closed against the pattern when used
	pos_vec_t step_nxt;
	logic     step_hit;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       empty_s1;
	logic       last_s1;

	// result register
	logic       out_valid_q;
	logic       matched_q;

	logic       in_acc;
	logic       s1_go;

	swm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pat       (pat)
	);

	swm_step u_step (
		.state     (state_q),
		.pat       (pat),
		.text_char (char_s1),
		.is_empty  (empty_s1),
		.nxt       (step_nxt),
		.hit_end   (step_hit)
	);

	// A non-last beat always retires; a last beat needs the result register
	// free or being drained this cycle.
	assign s1_go    = valid_s1 & (~last_s1 | ~out_valid_q | ~out_stall);
	assign in_stall = cfg_we | (valid_s1 & ~s1_go);
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc | (valid_s1 & ~s1_go);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			char_s1  <= text_char;
			empty_s1 <= is_empty;
			last_s1  <= last;
		end
	end

	// Position set. A config write leaves it alone; the step logic trims and
	// re-closes it against whatever pattern is in force when the next beat runs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= POS_W'(1);
		end else if (s1_go) begin
			state_q <= last_s1 ? POS_W'(1) : step_nxt;
		end
	end

	// result register: holds while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (s1_go & last_s1) | (out_valid_q & out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go & last_s1) begin
			matched_q <= step_hit;
		end
	end

	assign out_valid = out_valid_q;
	assign matched   = matched_q;

endmodule

@@ hw/rtl/swm_cfg.sv @@
// Configuration registers of the star wildcard matcher: length and pattern words.
// Depends on swm_pkg; presents the pattern as a pat_t view.
module swm_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [swm_pkg::IDX_W-1:0]   cfg_index,
	input  logic [swm_pkg::DATA_W-1:0]  cfg_data,
	output swm_pkg::pat_t               pat
);
	import swm_pkg::*;

	logic [LEN_W-1:0]                       length_q;
	logic [PAT_WORDS-1:0][DATA_W-1:0]       word_q;
	logic [LEN_W-1:0]                       len_use;
	logic [IDX_W-1:0]                       word_off;
	logic [WSEL_W-1:0]                      word_sel;

	assign word_off = cfg_index - REG_WORD0;
	assign word_sel = word_off[WSEL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			word_q   <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_LEN) begin
				length_q <= cfg_data[LEN_W-1:0];
			end else if (cfg_index >= REG_WORD0 && cfg_index <= REG_WORDN) begin
				word_q[word_sel] <= cfg_data;
			end
		end
	end

	// lengths above the store size clamp to it
	assign len_use = (length_q > LEN_W'(PAT_MAX)) ? LEN_W'(PAT_MAX) : length_q;

	always_comb begin
		pat.bytes = word_q;
		pat.len   = len_use;
		for (int p = 0; p < POS_W; p++) begin
			pat.live[p] = (LEN_W'(p) <= len_use);
		end
		pat.star = '0;
		for (int p = 0; p < PAT_MAX; p++) begin
			pat.star[p] = (LEN_W'(p) < len_use) && (word_q[p / 8][(p % 8) * 8 +: 8] == STAR_BYTE);
		end
	end

endmodule

@@ hw/rtl/swm_step.sv @@
// Combinational; depends on swm_pkg. One text beat on the stored position set: closure under
// the current pattern, literal shifts, star loops, closure again; empty beat: closure only.
module swm_step (
	input  swm_pkg::pos_vec_t  state,
	input  swm_pkg::pat_t      pat,
	input  logic [7:0]         text_char,
	input  logic               is_empty,
	output swm_pkg::pos_vec_t  nxt,
	output logic               hit_end
);
	import swm_pkg::*;

	pos_vec_t cur;
	pos_vec_t shifted;
	pos_vec_t raw;

	always_comb begin
		// stored set may predate a pattern change: trim and close it first
		cur     = close_stars(state, pat.star, pat.live);
		shifted = '0;
		for (int p = 0; p < PAT_MAX; p++) begin
			// literal at p < len that equals the byte moves on to p+1
			shifted[p + 1] = cur[p] & ~pat.star[p] & pat.live[p + 1] &
				(pat.bytes[p] == text_char);
		end
		raw = (cur & pat.star) | shifted;
		nxt = is_empty ? cur : close_stars(raw, pat.star, pat.live);
	end

	assign hit_end = nxt[pat.len];

endmodule

@@ hw/rtl/swm_checker.sv @@
// Port-level checks for the star wildcard matcher, bound to the top level.
// Depends only on the top-level ports.
module swm_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic in_valid,
	input logic in_stall,
	input logic last,
	input logic out_valid,
	input logic out_stall,
	input logic matched
);
	logic [1:0] pend_q;   // last beats accepted whose result is not yet taken
	logic       last_acc;
	logic       out_acc;

	assign last_acc = in_valid & ~in_stall & last;
	assign out_acc  = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, last_acc} - {1'b0, out_acc};
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(matched))
		else $error("stalled result changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 2'd0)
		else $error("result without an accepted last beat");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two results outstanding");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> in_stall)
		else $error("beat taken during a config write");

endmodule

bind star_wildcard_matcher swm_checker u_swm_checker (.*);
